// ----- rtl/mtms_pkg.sv -----
// ============================================================================
// mtms_pkg
// Shared widths, constants and arithmetic for the multi-stream MT19937 block.
// ============================================================================
package mtms_pkg;

   localparam int WORD_W          = 32;
   localparam int STREAM_W        = 7;
   localparam int COMMAND_W       = 1;
   localparam int POS_W           = 10;
   localparam int STREAM_LIMIT_W  = 11;
   localparam int STREAMS_DEFAULT = 128;
   localparam int STATE_WORDS     = 624;

   localparam logic [COMMAND_W-1:0] CMD_SEED = 1'b0;
   localparam logic [COMMAND_W-1:0] CMD_DRAW = 1'b1;

   localparam logic [POS_W-1:0] POS_FULL     = 10'd624;
   localparam logic [POS_W-1:0] POS_UNSEEDED = 10'd625;
   localparam logic [POS_W-1:0] LAST_WORD    = 10'd623;
   localparam logic [POS_W-1:0] SHIFT_SPAN   = 10'd397;
   localparam logic [POS_W-1:0] SPAN_BACK    = 10'd227;

   localparam logic [WORD_W-1:0] TWIST_XOR    = 32'h9908_b0df;
   localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
   localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
   localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
   localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
   localparam logic [16:0]       LCG_MULT     = 17'd69069;

   function automatic logic [WORD_W-1:0] twist_word(
      input logic [WORD_W-1:0] w_k,
      input logic [WORD_W-1:0] w_nxt,
      input logic [WORD_W-1:0] w_far
   );
      logic [WORD_W-1:0] y;
      y = (w_k & HIGH_BIT) | (w_nxt & LOW_BITS);
      return w_far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
   endfunction

   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] y;
      y = x;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// ----- rtl/mtms_if.sv -----
// ============================================================================
// mtms_req_if / mtms_rsp_if
// Valid/ready channels for commands into and words out of the generator bank.
// ============================================================================
interface mtms_req_if;
   logic                               valid;
   logic                               ready;
   logic [mtms_pkg::COMMAND_W-1:0]     command;
   logic [mtms_pkg::STREAM_W-1:0]      stream;
   logic [mtms_pkg::WORD_W-1:0]        seed_value;

   modport source (output valid, output command, output stream, output seed_value,
                   input ready);
   modport sink   (input valid, input command, input stream, input seed_value,
                   output ready);
endinterface

interface mtms_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mtms_pkg::WORD_W-1:0]   random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

// ----- rtl/mtms_ram.sv -----
// ============================================================================
// mtms_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module mtms_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/multi_stream_mersenne_twister.sv -----
// ============================================================================
// multi_stream_mersenne_twister
// Bank of independent MT19937 generators with state held in block RAM.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+---------------------------------
//   req_port | in  | valid / ready | command, stream, seed_value
//   rsp_port | out | valid / ready | random_word
//
// A seed runs from acceptance through a position lookup, then one word written
// per cycle by the 69069 multiplier. A draw makes the three reads and one write
// that a lazy twist needs on the single-read word RAM; a draw of an unseeded
// stream first runs the default seed. After reset the position RAM is swept,
// one entry per stream, before the first transaction is accepted. A waiting
// result only holds a later draw at its final step; commands are accepted while
// it waits.
// ============================================================================
module multi_stream_mersenne_twister #(
   parameter int STREAMS = mtms_pkg::STREAMS_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   mtms_req_if.sink   req_port,
   mtms_rsp_if.source rsp_port
);

   import mtms_pkg::*;

   localparam int IDX_W    = (STREAMS > 1) ? $clog2(STREAMS) : 1;
   localparam int MEM_WORDS = STREAMS * STATE_WORDS;
   localparam int ADDR_W   = $clog2(MEM_WORDS);
   localparam logic [STREAM_LIMIT_W-1:0] STREAM_LIMIT = STREAM_LIMIT_W'(STREAMS);
   localparam logic [IDX_W-1:0]          LAST_STREAM  = IDX_W'(STREAMS - 1);

   typedef enum logic [8:0] {
      ST_CLEAR    = 9'b000000001,
      ST_IDLE     = 9'b000000010,
      ST_LOOKUP   = 9'b000000100,
      ST_SEED     = 9'b000001000,
      ST_ADDR_K   = 9'b000010000,
      ST_ADDR_NXT = 9'b000100000,
      ST_ADDR_FAR = 9'b001000000,
      ST_TWIST    = 9'b010000000,
      ST_OUT      = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [COMMAND_W-1:0] command_ff, command_in;
   logic [IDX_W-1:0]     stream_ff, stream_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [WORD_W-1:0]    seed_word_ff, seed_word_in;
   logic                 draw_pend_ff, draw_pend_in;
   logic [POS_W-1:0]     k_ff, k_in;
   logic [WORD_W-1:0]    w_k_ff, w_k_in;
   logic [WORD_W-1:0]    w_nxt_ff, w_nxt_in;
   logic [WORD_W-1:0]    twisted_ff, twisted_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_word_ff, rsp_word_in;

   logic [STREAM_LIMIT_W-1:0] req_stream_ext;
   logic [IDX_W-1:0]          req_idx;
   logic                      req_in_range;
   logic                      req_accept;
   logic                      rsp_free;
   logic [POS_W-1:0]          nxt_off;
   logic [POS_W-1:0]          far_off;
   logic [48:0]               seed_prod;
   logic [WORD_W-1:0]         twist_val;

   logic              word_we, word_re;
   logic [ADDR_W-1:0] word_waddr, word_raddr;
   logic [WORD_W-1:0] word_wdata, word_rdata;
   logic              pos_we, pos_re;
   logic [IDX_W-1:0]  pos_waddr;
   logic [POS_W-1:0]  pos_wdata, pos_rdata;

   assign req_stream_ext = STREAM_LIMIT_W'(req_port.stream);
   assign req_idx        = req_stream_ext[IDX_W-1:0];
   assign req_in_range   = req_stream_ext < STREAM_LIMIT;
   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_port.valid && req_port.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;

   assign nxt_off   = (k_ff == LAST_WORD) ? '0 : k_ff + 10'd1;
   assign far_off   = (k_ff < SPAN_BACK) ? k_ff + SHIFT_SPAN : k_ff - SPAN_BACK;
   assign seed_prod = seed_word_ff * LCG_MULT;
   assign twist_val = twist_word(w_k_ff, w_nxt_ff, word_rdata);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      command_in   = command_ff;
      stream_in    = stream_ff;
      base_in      = base_ff;
      seed_word_in = seed_word_ff;
      draw_pend_in = draw_pend_ff;
      k_in         = k_ff;
      w_k_in       = w_k_ff;
      w_nxt_in     = w_nxt_ff;
      twisted_in   = twisted_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;

      word_we    = 1'b0;
      word_waddr = base_ff + ADDR_W'(k_ff);
      word_wdata = seed_word_ff;
      word_re    = 1'b0;
      word_raddr = base_ff + ADDR_W'(k_ff);
      pos_we     = 1'b0;
      pos_waddr  = stream_ff;
      pos_wdata  = POS_FULL;
      pos_re     = req_accept;

      unique case (state_ff)
         ST_CLEAR: begin
            pos_we    = 1'b1;
            pos_waddr = clr_ff;
            pos_wdata = POS_UNSEEDED;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_STREAM) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && req_in_range) begin
               command_in   = req_port.command;
               stream_in    = req_idx;
               base_in      = ADDR_W'(ADDR_W'(req_idx) * ADDR_W'(STATE_WORDS));
               seed_word_in = req_port.seed_value;
               state_in     = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            k_in         = '0;
            draw_pend_in = 1'b0;
            if (command_ff == CMD_SEED) begin
               state_in = ST_SEED;
            end else if (pos_rdata == POS_UNSEEDED) begin
               seed_word_in = DEFAULT_SEED;
               draw_pend_in = 1'b1;
               state_in     = ST_SEED;
            end else begin
               if (pos_rdata < POS_FULL) begin
                  k_in = pos_rdata;
               end
               state_in = ST_ADDR_K;
            end
         end
         ST_SEED: begin
            word_we      = 1'b1;
            seed_word_in = seed_prod[WORD_W-1:0];
            k_in         = k_ff + 10'd1;
            if (k_ff == LAST_WORD) begin
               pos_we = 1'b1;
               k_in   = '0;
               state_in = draw_pend_ff ? ST_ADDR_K : ST_IDLE;
            end
         end
         ST_ADDR_K: begin
            word_re  = 1'b1;
            state_in = ST_ADDR_NXT;
         end
         ST_ADDR_NXT: begin
            word_re    = 1'b1;
            word_raddr = base_ff + ADDR_W'(nxt_off);
            w_k_in     = word_rdata;
            state_in   = ST_ADDR_FAR;
         end
         ST_ADDR_FAR: begin
            word_re    = 1'b1;
            word_raddr = base_ff + ADDR_W'(far_off);
            w_nxt_in   = word_rdata;
            state_in   = ST_TWIST;
         end
         ST_TWIST: begin
            word_we    = 1'b1;
            word_wdata = twist_val;
            twisted_in = twist_val;
            pos_we     = 1'b1;
            pos_wdata  = k_ff + 10'd1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_word_in  = temper(twisted_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff   <= command_in;
      stream_ff    <= stream_in;
      base_ff      <= base_in;
      seed_word_ff <= seed_word_in;
      draw_pend_ff <= draw_pend_in;
      k_ff         <= k_in;
      w_k_ff       <= w_k_in;
      w_nxt_ff     <= w_nxt_in;
      twisted_ff   <= twisted_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.random_word = rsp_word_ff;

   mtms_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (MEM_WORDS),
      .ADDR_W (ADDR_W)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (word_we),
      .wr_addr (word_waddr),
      .wr_data (word_wdata),
      .rd_en   (word_re),
      .rd_addr (word_raddr),
      .rd_data (word_rdata)
   );

   mtms_ram #(
      .WIDTH  (POS_W),
      .DEPTH  (STREAMS),
      .ADDR_W (IDX_W)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (pos_wdata),
      .rd_en   (pos_re),
      .rd_addr (req_idx),
      .rd_data (pos_rdata)
   );

   // The twist only ever works on one of the 624 words of the current stream.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TWIST |-> k_ff < POS_FULL)
      else $error("twist index beyond the state words");

   // The word RAM is never written and read in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(word_we && word_re))
      else $error("word RAM read and write collide");

   // A new result appears only after the output step of a draw.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   // A finished seed either returns to idle or continues into the pending draw.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEED && k_ff == LAST_WORD
         |=> state_ff == ST_ADDR_K || state_ff == ST_IDLE)
      else $error("seed sweep ended in an unexpected state");

endmodule
